/* rtl/bgf_pkg.sv */
package bgf_pkg;

    // Width of one byte of the store and of the bit fields of a transaction.
    localparam int BYTE_W = 8;

    // Width of the bit count field.
    localparam int COUNT_W = 4;

    // Largest number of bits moved by one transaction; larger counts saturate.
    localparam int MAX_BITS_PER_ITEM = 8;

    // Operation carried by an input transaction.
    typedef enum logic [0:0] {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

endpackage

/* rtl/bgf_if.sv */
// Input channel: one push or pop request per transaction.
interface bgf_in_if import bgf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_action              action;
    logic [COUNT_W-1:0]   bit_count;
    logic [BYTE_W-1:0]    push_bits;

    modport source (output valid, output action, output bit_count, output push_bits,
                    input ready);
    modport sink   (input valid, input action, input bit_count, input push_bits,
                    output ready);
endinterface

// Output channel: one result per request.
interface bgf_out_if import bgf_pkg::*; #(parameter int HELD_W = 10) ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    pop_bits;
    logic [HELD_W-1:0]    bits_held;
    logic                 underflow;
    logic                 overflow;

    modport source (output valid, output pop_bits, output bits_held, output underflow,
                    output overflow, input ready);
    modport sink   (input valid, input pop_bits, input bits_held, input underflow,
                    input overflow, output ready);
endinterface

/* rtl/bit_granular_fifo_top.sv */
// Channel   Direction  Fields                                     Transfer
// i_in      sink       action, bit_count, push_bits               valid && ready
// o_out     source     pop_bits, bits_held, underflow, overflow   valid && ready
//
// One transaction per clock cycle while o_out is not stalled; each taken request passes
// through the input register, then the result register, before its result appears.
// The byte store is a RAM with registered reads, addressed from the next read pointer;
// a partial tail byte is held in a register until it fills.
// Synchronous active-low reset clears pointers, fill count and both valid flags;
// i_in.ready is low while reset is asserted. A stalled o_out holds the result and
// the waiting request, and i_in.ready drops once both registers are full.
module bit_granular_fifo_top import bgf_pkg::*; #(
    parameter int CAPACITY_BYTES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bgf_in_if.sink    i_in,
    bgf_out_if.source o_out
);

    localparam int TOTAL_BITS = CAPACITY_BYTES * 8;
    localparam int AW         = $clog2(CAPACITY_BYTES);
    localparam int HW         = $clog2(TOTAL_BITS + 1);
    localparam int FW         = HW + 1;

    // Next byte index with wrap at the end of the store.
    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        logic [AW-1:0] res;
        if (a == AW'(CAPACITY_BYTES - 1)) begin
            res = '0;
        end else begin
            res = a + AW'(1);
        end
        return res;
    endfunction

    // Input register.
    logic               r_in_valid;
    t_action            r_action;
    logic [COUNT_W-1:0] r_count;
    logic [BYTE_W-1:0]  r_data;

    // Pointers, fill count and the partial tail byte.
    logic [AW-1:0]      r_rd_byte, n_rd_byte;
    logic [2:0]         r_rd_off,  n_rd_off;
    logic [AW-1:0]      r_wr_byte, n_wr_byte;
    logic [2:0]         r_wr_off,  n_wr_off;
    logic [HW-1:0]      r_fill,    n_fill;
    logic [BYTE_W-1:0]  r_tail,    n_tail;

    // Write forwarding for the cycle after a RAM write.
    logic               r_byp_valid;
    logic [AW-1:0]      r_byp_addr;
    logic [BYTE_W-1:0]  r_byp_data;

    // Result register.
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_pop;
    logic [HW-1:0]      r_out_held;
    logic               r_out_under;
    logic               r_out_over;

    logic               process;
    logic               in_accept;
    logic [COUNT_W-1:0] cnt;
    logic [BYTE_W-1:0]  cnt_mask;
    logic [BYTE_W-1:0]  tail_mask;
    logic [AW-1:0]      rd_byte1;
    logic [BYTE_W-1:0]  ram_a, ram_b;
    logic [BYTE_W-1:0]  raw0, raw1;
    logic [BYTE_W-1:0]  byte0, byte1;
    logic [15:0]        window;
    logic [BYTE_W-1:0]  popped;
    logic [BYTE_W-1:0]  pushed;
    logic [15:0]        joined;
    logic [3:0]         rd_sum, wr_sum;
    logic [FW-1:0]      fill_ext, cnt_ext;
    logic               is_push, is_pop;
    logic               over, under;
    logic               ram_we;
    logic [AW-1:0]      ram_wr_addr;
    logic [BYTE_W-1:0]  ram_wr_data;
    logic [BYTE_W-1:0]  n_pop_bits;

    // Handshakes: a request is processed when the result register can take it.
    assign process     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = i_rst_n && (!r_in_valid || process);
    assign in_accept   = i_in.valid && i_in.ready;

    // Saturated bit count and the masks built from it and the tail offset.
    assign cnt       = (r_count > COUNT_W'(MAX_BITS_PER_ITEM)) ?
                       COUNT_W'(MAX_BITS_PER_ITEM) : r_count;
    assign cnt_mask  = BYTE_W'((9'd1 << cnt) - 9'd1);
    assign tail_mask = BYTE_W'((9'd1 << r_wr_off) - 9'd1);

    // The two bytes under the read pointer, with forwarding of last cycle's write.
    assign rd_byte1 = f_inc(r_rd_byte);
    assign raw0     = (r_byp_valid && r_byp_addr == r_rd_byte) ? r_byp_data : ram_a;
    assign raw1     = (r_byp_valid && r_byp_addr == rd_byte1)  ? r_byp_data : ram_b;

    // The byte under the write pointer takes its newest bits from the tail register.
    assign byte0 = (r_rd_byte == r_wr_byte) ? ((r_tail & tail_mask) | (raw0 & ~tail_mask))
                                            : raw0;
    assign byte1 = (rd_byte1 == r_wr_byte)  ? ((r_tail & tail_mask) | (raw1 & ~tail_mask))
                                            : raw1;

    // Pop data: shift the two-byte window down to the read offset.
    assign window = {byte1, byte0} >> r_rd_off;
    assign popped = window[BYTE_W-1:0] & cnt_mask;

    // Push data: place the new bits above the tail's held bits.
    assign pushed = r_data & cnt_mask;
    assign joined = {8'h00, r_tail & tail_mask} | ({8'h00, pushed} << r_wr_off);

    assign rd_sum   = {1'b0, r_rd_off} + cnt;
    assign wr_sum   = {1'b0, r_wr_off} + cnt;
    assign fill_ext = {1'b0, r_fill};
    assign cnt_ext  = FW'(cnt);

    assign is_push = (r_action == ACT_PUSH);
    assign is_pop  = (r_action == ACT_POP);
    assign over    = is_push && ((fill_ext + cnt_ext) > FW'(TOTAL_BITS));
    assign under   = is_pop && (cnt_ext > fill_ext);

    // Next state of pointers, fill count and tail, and the RAM write of a full byte.
    always_comb begin
        n_rd_byte   = r_rd_byte;
        n_rd_off    = r_rd_off;
        n_wr_byte   = r_wr_byte;
        n_wr_off    = r_wr_off;
        n_fill      = r_fill;
        n_tail      = r_tail;
        n_pop_bits  = '0;
        ram_we      = 1'b0;
        ram_wr_addr = r_wr_byte;
        ram_wr_data = joined[BYTE_W-1:0];
        if (process) begin
            if (is_push && !over) begin
                n_wr_off = wr_sum[2:0];
                n_fill   = r_fill + HW'(cnt);
                if (wr_sum[3]) begin
                    ram_we    = 1'b1;
                    n_wr_byte = f_inc(r_wr_byte);
                    n_tail    = joined[15:8];
                end else begin
                    n_tail = joined[BYTE_W-1:0];
                end
            end else if (is_pop && !under) begin
                n_rd_off   = rd_sum[2:0];
                n_fill     = r_fill - HW'(cnt);
                n_pop_bits = popped;
                if (rd_sum[3]) begin
                    n_rd_byte = rd_byte1;
                end
            end
        end
    end

    // Byte store, read at the bytes under the next read pointer.
    bgf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY_BYTES)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (ram_we),
        .i_wr_addr   (ram_wr_addr),
        .i_wr_data   (ram_wr_data),
        .i_rd_addr_a (n_rd_byte),
        .o_rd_data_a (ram_a),
        .i_rd_addr_b (f_inc(n_rd_byte)),
        .o_rd_data_b (ram_b)
    );

    // Control state: valid flags, pointers, fill count and forwarding flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_byte   <= '0;
            r_rd_off    <= '0;
            r_wr_byte   <= '0;
            r_wr_off    <= '0;
            r_fill      <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_byte   <= n_rd_byte;
            r_rd_off    <= n_rd_off;
            r_wr_byte   <= n_wr_byte;
            r_wr_off    <= n_wr_off;
            r_fill      <= n_fill;
            r_byp_valid <= ram_we;
        end
    end

    // Payload registers: request, tail, forwarded byte and result.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= i_in.action;
            r_count  <= i_in.bit_count;
            r_data   <= i_in.push_bits;
        end
        r_tail <= n_tail;
        if (ram_we) begin
            r_byp_addr <= ram_wr_addr;
            r_byp_data <= ram_wr_data;
        end
        if (process) begin
            r_out_pop   <= n_pop_bits;
            r_out_held  <= n_fill;
            r_out_under <= under;
            r_out_over  <= over;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pop_bits  = r_out_pop;
    assign o_out.bits_held = r_out_held;
    assign o_out.underflow = r_out_under;
    assign o_out.overflow  = r_out_over;

endmodule

/* rtl/bgf_ram.sv */
module bgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    // One write port; a read in the same cycle returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data_a <= r_mem[i_rd_addr_a];
        r_rd_data_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

/* dv/bit_granular_fifo_checker.sv */
module bit_granular_fifo_checker import bgf_pkg::*; #(
    parameter int CAPACITY_BYTES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bgf_in_if    i_req,
    bgf_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BITS = CAPACITY_BYTES * BYTE_W;
    localparam int PTR_W      = $clog2(TOTAL_BITS);
    localparam int HELD_W     = $clog2(TOTAL_BITS + 1);

    // One result of the bit stream as the block should report it.
    typedef struct packed {
        logic [BYTE_W-1:0] pop_bits;
        logic [HELD_W-1:0] bits_held;
        logic              underflow;
        logic              overflow;
    } t_fifo_result;

    // Shadow copy of the bit stream.
    logic [BYTE_W-1:0] shadow_bytes [CAPACITY_BYTES];
    logic [PTR_W-1:0]  shadow_rd_ptr;
    logic [PTR_W-1:0]  shadow_wr_ptr;
    logic [HELD_W-1:0] shadow_fill;

    t_fifo_result awaited_results [$];

    // Applies one push or pop to the shadow stream and returns the result it gives.
    function automatic t_fifo_result stream_step(t_action act, logic [COUNT_W-1:0] cnt,
                                                 logic [BYTE_W-1:0] data);
        t_fifo_result       res;
        logic [COUNT_W-1:0] n;
        int                 i;
        res = '0;
        n = (cnt > COUNT_W'(MAX_BITS_PER_ITEM)) ? COUNT_W'(MAX_BITS_PER_ITEM) : cnt;
        if (act == ACT_PUSH) begin
            if (int'(shadow_fill) + int'(n) > TOTAL_BITS) begin
                res.overflow = 1'b1;
            end else begin
                for (i = 0; i < int'(n); i++) begin
                    shadow_bytes[shadow_wr_ptr[PTR_W-1:3]][shadow_wr_ptr[2:0]] = data[i];
                    shadow_wr_ptr = (int'(shadow_wr_ptr) == TOTAL_BITS - 1) ? '0
                                                                          : shadow_wr_ptr + 1'b1;
                end
                shadow_fill = shadow_fill + HELD_W'(n);
            end
        end else begin
            if (HELD_W'(n) > shadow_fill) begin
                res.underflow = 1'b1;
            end else begin
                for (i = 0; i < int'(n); i++) begin
                    res.pop_bits[i] = shadow_bytes[shadow_rd_ptr[PTR_W-1:3]][shadow_rd_ptr[2:0]];
                    shadow_rd_ptr = (int'(shadow_rd_ptr) == TOTAL_BITS - 1) ? '0
                                                                          : shadow_rd_ptr + 1'b1;
                end
                shadow_fill = shadow_fill - HELD_W'(n);
            end
        end
        res.bits_held = shadow_fill;
        return res;
    endfunction

    // Compare each finished transaction with the oldest prediction, then predict the
    // result of each newly taken request.
    always @(posedge i_clk) begin
        t_fifo_result want;
        if (!i_rst_n) begin
            shadow_rd_ptr = '0;
            shadow_wr_ptr = '0;
            shadow_fill   = '0;
            awaited_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction arrived with no request outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp.pop_bits !== want.pop_bits ||
                        i_rsp.bits_held !== want.bits_held ||
                        i_rsp.underflow !== want.underflow ||
                        i_rsp.overflow !== want.overflow) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (i_rsp.pop_bits !== want.pop_bits)
                        $error("pop_bits: expected %0h, actual %0h",
                               want.pop_bits, i_rsp.pop_bits);
                    if (i_rsp.bits_held !== want.bits_held)
                        $error("bits_held: expected %0d, actual %0d",
                               want.bits_held, i_rsp.bits_held);
                    if (i_rsp.underflow !== want.underflow)
                        $error("underflow: expected %0b, actual %0b",
                               want.underflow, i_rsp.underflow);
                    if (i_rsp.overflow !== want.overflow)
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, i_rsp.overflow);
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_results = {awaited_results,
                                   stream_step(i_req.action, i_req.bit_count,
                                               i_req.push_bits)};
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

/* dv/bit_granular_fifo_top_tb.sv */
module bit_granular_fifo_top_tb import bgf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY_BYTES = 64;
    localparam int TARGET_ITEMS   = 800;
    localparam int CYCLE_LIMIT    = 200000;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } t_phase;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   burst_left  = 0;

    // Receiver stall pattern state.
    int          rx_mode      = 0;
    int          rx_mode_left = 0;
    int          rx_run_left  = 0;

    bgf_in_if                                         in_if ();
    bgf_out_if #(.HELD_W($clog2(CAPACITY_BYTES * 8 + 1))) out_if ();

    bit_granular_fifo_top #(.CAPACITY_BYTES(CAPACITY_BYTES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    bit_granular_fifo_checker #(.CAPACITY_BYTES(CAPACITY_BYTES)) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_if),
        .i_rsp        (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // Stop a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver switches between always ready, random stalls and ready/stall runs.
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(40, 160);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0: begin
                out_if.ready <= 1'b1;
            end
            1: begin
                out_if.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (rx_run_left == 0) begin
                    out_if.ready <= ~out_if.ready;
                    rx_run_left  <= $urandom_range(1, 12);
                end else begin
                    rx_run_left <= rx_run_left - 1;
                end
            end
        endcase
    end

    // Offers one request and holds it until it is taken; bursts may end in a random gap.
    task automatic send_item(input t_action act, input logic [COUNT_W-1:0] cnt,
                             input logic [BYTE_W-1:0] data);
        int unsigned gap;
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.action    <= act;
        in_if.bit_count <= cnt;
        in_if.push_bits <= data;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // One random request; wide counts speed up filling and draining the stream.
    task automatic send_random(input int unsigned push_pct, input bit wide);
        t_action            act;
        logic [COUNT_W-1:0] cnt;
        act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
        case ($urandom_range(0, 19))
            0: cnt = '0;
            1: cnt = COUNT_W'($urandom_range(9, 15));
            default: cnt = wide ? COUNT_W'($urandom_range(5, 8)) : COUNT_W'($urandom_range(1, 8));
        endcase
        send_item(act, cnt, BYTE_W'($urandom));
    endtask

    initial begin
        t_phase      phase;
        int          sent;
        int          phase_len;
        int unsigned push_pct;
        int          i;

        in_if.valid     = 1'b0;
        in_if.action    = ACT_PUSH;
        in_if.bit_count = '0;
        in_if.push_bits = '0;
        out_if.ready    = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty stream, zero and saturated counts, partial and full bytes.
        send_item(ACT_POP,  4'd1,  8'hFF);
        send_item(ACT_POP,  4'd0,  8'h00);
        send_item(ACT_PUSH, 4'd0,  8'hFF);
        send_item(ACT_PUSH, 4'd8,  8'hA5);
        send_item(ACT_PUSH, 4'd1,  8'hFF);
        send_item(ACT_PUSH, 4'd15, 8'h3C);
        send_item(ACT_PUSH, 4'd3,  8'hFF);
        send_item(ACT_POP,  4'd0,  8'hFF);
        send_item(ACT_POP,  4'd9,  8'h00);
        send_item(ACT_POP,  4'd3,  8'h55);
        send_item(ACT_POP,  4'd15, 8'h00);
        send_item(ACT_POP,  4'd8,  8'hFF);
        send_item(ACT_POP,  4'd1,  8'h00);
        send_item(ACT_POP,  4'd1,  8'h00);
        send_item(ACT_PUSH, 4'd8,  8'h00);
        send_item(ACT_PUSH, 4'd8,  8'hFF);
        send_item(ACT_PUSH, 4'd7,  8'h5A);
        send_item(ACT_POP,  4'd2,  8'h00);
        send_item(ACT_POP,  4'd8,  8'h00);
        send_item(ACT_POP,  4'd8,  8'h00);
        send_item(ACT_POP,  4'd5,  8'h00);
        send_item(ACT_POP,  4'd1,  8'h00);
        wait_drained();

        // Random part in phases; the first one mostly pushes to fill the stream.
        sent  = 0;
        phase = PHASE_FILL;
        while (sent < TARGET_ITEMS) begin
            phase_len = $urandom_range(60, 140);
            case (phase)
                PHASE_FILL:  push_pct = 92;
                PHASE_DRAIN: push_pct = 8;
                default:     push_pct = 50;
            endcase
            for (i = 0; i < phase_len; i++) begin
                send_random(push_pct, phase != PHASE_MIXED);
            end
            sent += phase_len;
            if ($urandom_range(0, 1) == 0) wait_drained();
            phase = t_phase'($urandom_range(0, 2));
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
